// File: hdl/ppmw_pkg.sv
// Shared types, constants and helpers for the ppm window ion chromatogram unit.
// Used by every module under hdl; depends on nothing.
package ppmw_pkg;

  // Sizing
  localparam int NUM_TARGETS = 4;
  localparam int NUM_BINS    = 128;

  // Field widths
  localparam int SCAN_W  = 24;
  localparam int MASS_W  = 32;
  localparam int INTEN_W = 32;
  localparam int TSEL_W  = 2;
  localparam int BSEL_W  = 8;
  localparam int ACC_W   = 48;
  localparam int HB_W    = 7;
  localparam int TOL_W   = 17;
  localparam int TCNT_W  = 3;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;

  // Scan to bin mapping
  localparam int SCAN_FIRST   = 120;
  localparam int SCAN_PER_BIN = 60;
  localparam int TOTAL_SELECT = 128;

  // ppm scaling: 1e6 for ppm times 100 for hundredths
  localparam longint PPM_SCALE = 100000000;
  localparam int     PPM_W     = 27;

  localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int TIDX_W    = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int ACT_W     = $clog2(NUM_TARGETS + 1);
  localparam int MEM_DEPTH = NUM_BINS * NUM_TARGETS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Scan offsets below SPAN land in a bin; divide by 60 through a reciprocal
  localparam int SPAN      = NUM_BINS * SCAN_PER_BIN;
  localparam int SPAN_W    = $clog2(SPAN);
  localparam int DIV_SHIFT = 24;
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + SCAN_PER_BIN - 1) / SCAN_PER_BIN;
  localparam int RECIP_W   = $clog2(DIV_RECIP + 1);

  localparam int HB_MAX = (NUM_BINS - 1 < 127) ? NUM_BINS - 1 : 127;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_TOL    = 3'd0,
    CFG_TCNT   = 3'd1,
    CFG_MASS_A = 3'd2,
    CFG_MASS_B = 3'd3,
    CFG_MASS_C = 3'd4,
    CFG_MASS_D = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic               action;
    logic [SCAN_W-1:0]  scan_number;
    logic [MASS_W-1:0]  point_mass;
    logic [INTEN_W-1:0] point_intensity;
    logic [TSEL_W-1:0]  target_select;
    logic [BSEL_W-1:0]  bin_select;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] read_value;
    logic [HB_W-1:0]  highest_bin;
  } out_item_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    op_e                op;
    logic [SCAN_W-1:0]  scan;
    logic [MASS_W-1:0]  mass;
    logic [INTEN_W-1:0] inten;
    logic [TSEL_W-1:0]  tsel;
    logic [BSEL_W-1:0]  bsel;
    logic [BIN_W-1:0]   bin;
    logic               bin_ok;
    logic [HB_W-1:0]    hb;
  } entry_t;

  typedef struct packed {
    logic [TOL_W-1:0]                   tol;
    logic [ACT_W-1:0]                   act;
    logic [NUM_TARGETS-1:0][MASS_W-1:0] mass;
  } cfg_t;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [INTEN_W-1:0] v);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W + 1)'(v);
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

endpackage

// File: hdl/ppmw_front.sv
// Front end: accepts input items, drops skipped points, computes the time bin.
// Depends on ppmw_pkg; feeds ppmw_queue.
module ppmw_front (
  input  logic               in_valid_i,
  input  ppmw_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  input  logic               clearing_i,
  output logic               in_stall_o,
  output logic               push_o,
  output ppmw_pkg::entry_t   entry_o
);

  logic                                           scan_ok;
  logic                                           skip;
  logic [ppmw_pkg::SCAN_W-1:0]                    x;
  logic                                           bin_ok;
  logic [ppmw_pkg::SPAN_W+ppmw_pkg::RECIP_W-1:0]  prod;
  logic [ppmw_pkg::BIN_W-1:0]                     bin;

  always_comb begin
    in_stall_o = clearing_i | q_full_i;
    scan_ok    = in_item_i.scan_number >= ppmw_pkg::SCAN_W'(ppmw_pkg::SCAN_FIRST);
    skip       = (in_item_i.action == ppmw_pkg::OP_ACC) &&
                 (!scan_ok || (in_item_i.point_intensity == '0));
    x          = in_item_i.scan_number - ppmw_pkg::SCAN_W'(ppmw_pkg::SCAN_FIRST);
    bin_ok     = x < ppmw_pkg::SCAN_W'(ppmw_pkg::SPAN);
    // exact for every offset below the span
    prod       = x[ppmw_pkg::SPAN_W-1:0] *
                 ppmw_pkg::RECIP_W'(ppmw_pkg::DIV_RECIP);
    bin        = prod[ppmw_pkg::DIV_SHIFT +: ppmw_pkg::BIN_W];

    entry_o.op     = ppmw_pkg::op_e'(in_item_i.action);
    entry_o.scan   = in_item_i.scan_number;
    entry_o.mass   = in_item_i.point_mass;
    entry_o.inten  = in_item_i.point_intensity;
    entry_o.tsel   = in_item_i.target_select;
    entry_o.bsel   = in_item_i.bin_select;
    entry_o.bin    = bin;
    entry_o.bin_ok = bin_ok;
    if (!bin_ok || (32'(bin) > ppmw_pkg::HB_MAX)) begin
      entry_o.hb = ppmw_pkg::HB_W'(ppmw_pkg::HB_MAX);
    end else begin
      entry_o.hb = ppmw_pkg::HB_W'(bin);
    end

    push_o = in_valid_i & ~in_stall_o & ~skip;
  end

endmodule

// File: hdl/ppmw_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on ppmw_pkg.
module ppmw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ppmw_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output ppmw_pkg::entry_t head_o
);

  ppmw_pkg::entry_t              mem_q [ppmw_pkg::QUEUE_DEPTH];
  logic [ppmw_pkg::QPTR_W-1:0]   wr_ptr_q;
  logic [ppmw_pkg::QPTR_W-1:0]   rd_ptr_q;
  logic [ppmw_pkg::QPTR_W:0]     count_q;

  always_comb begin
    full_o  = count_q == (ppmw_pkg::QPTR_W + 1)'(ppmw_pkg::QUEUE_DEPTH);
    valid_o = count_q != '0;
    head_o  = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ppmw_back.sv
// Back end: window match per target, saturating accumulators, bin memory,
// reads and the result register. Depends on ppmw_pkg.
module ppmw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppmw_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  ppmw_pkg::entry_t    q_head_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output ppmw_pkg::out_item_t out_item_o
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DIFF  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_ACC   = 7'b0010000,
    ST_RD    = 7'b0100000,
    ST_RDOUT = 7'b1000000
  } state_e;

  localparam int LHS_W = ppmw_pkg::MASS_W + ppmw_pkg::PPM_W;
  localparam int RHS_W = ppmw_pkg::MASS_W + ppmw_pkg::TOL_W;

  state_e                         state_q, state_d;
  ppmw_pkg::entry_t               item_q;
  logic [ppmw_pkg::TIDX_W-1:0]    t_q;
  logic [ppmw_pkg::ADDR_W-1:0]    clr_q;
  logic [ppmw_pkg::MASS_W-1:0]    diff_q;
  logic [RHS_W-1:0]               rhs_q;
  logic [LHS_W-1:0]               lhs_q;
  logic [ppmw_pkg::ACC_W-1:0]     rdata_q;
  logic [ppmw_pkg::ACC_W-1:0]     totals_q [ppmw_pkg::NUM_TARGETS];
  logic [ppmw_pkg::SCAN_W-1:0]    max_scan_q;
  logic [ppmw_pkg::HB_W-1:0]      hb_q;
  logic                           out_valid_q;
  ppmw_pkg::out_item_t            out_item_q;

  logic [ppmw_pkg::ACC_W-1:0]     bins_mem [ppmw_pkg::MEM_DEPTH];

  logic [ppmw_pkg::MASS_W-1:0]    tgt;
  logic [RHS_W-1:0]               rhs_prod;
  logic [LHS_W-1:0]               lhs_prod;
  logic                           hit;
  logic                           last;
  logic                           out_free;
  logic                           out_load;
  logic [ppmw_pkg::ADDR_W-1:0]    acc_addr;
  logic [ppmw_pkg::ADDR_W-1:0]    rd_addr;
  logic                           mem_re;
  logic                           mem_we;
  logic [ppmw_pkg::ADDR_W-1:0]    mem_raddr;
  logic [ppmw_pkg::ADDR_W-1:0]    mem_waddr;
  logic [ppmw_pkg::ACC_W-1:0]     mem_wdata;
  logic [ppmw_pkg::ACC_W-1:0]     rd_value;

  always_comb begin
    tgt      = cfg_i.mass[t_q];
    rhs_prod = tgt * cfg_i.tol;
    lhs_prod = diff_q * ppmw_pkg::PPM_W'(ppmw_pkg::PPM_SCALE);
    hit      = lhs_q <= LHS_W'(rhs_q);
    last     = (ppmw_pkg::ACT_W'(t_q) + ppmw_pkg::ACT_W'(1)) >= cfg_i.act;
    out_free = ~out_valid_q | ~out_stall_i;
    out_load = (state_q == ST_RDOUT) && out_free;
    acc_addr = ppmw_pkg::ADDR_W'(32'(item_q.bin) * ppmw_pkg::NUM_TARGETS + 32'(t_q));
    rd_addr  = ppmw_pkg::ADDR_W'(32'(item_q.bsel) * ppmw_pkg::NUM_TARGETS +
                                 32'(item_q.tsel));

    mem_re    = (state_q == ST_DIFF) || (state_q == ST_RD);
    mem_raddr = (state_q == ST_RD) ? rd_addr : acc_addr;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_q == ST_ACC) && hit && item_q.bin_ok;
      mem_waddr = acc_addr;
      mem_wdata = ppmw_pkg::sat_add(rdata_q, item_q.inten);
    end

    // unknown targets and bins read as zero
    rd_value = '0;
    if (32'(item_q.tsel) < ppmw_pkg::NUM_TARGETS) begin
      if (item_q.bsel == ppmw_pkg::BSEL_W'(ppmw_pkg::TOTAL_SELECT)) begin
        rd_value = totals_q[item_q.tsel[ppmw_pkg::TIDX_W-1:0]];
      end else if (32'(item_q.bsel) < ppmw_pkg::NUM_BINS) begin
        rd_value = rdata_q;
      end
    end

    q_pop_o    = (state_q == ST_IDLE) && q_valid_i;
    clearing_o = state_q == ST_CLEAR;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ppmw_pkg::ADDR_W'(ppmw_pkg::MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.op == ppmw_pkg::OP_READ) begin
            state_d = ST_RD;
          end else if (cfg_i.act != '0) begin
            state_d = ST_DIFF;
          end
        end
      end
      ST_DIFF:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = last ? ST_IDLE : ST_DIFF;
      ST_RD:    state_d = ST_RDOUT;
      ST_RDOUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Bin memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bins_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= bins_mem[mem_raddr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_head_i;
    end
    if (state_q == ST_DIFF) begin
      diff_q <= (item_q.mass >= tgt) ? item_q.mass - tgt : tgt - item_q.mass;
      rhs_q  <= rhs_prod;
    end
    if (state_q == ST_MUL) begin
      lhs_q <= lhs_prod;
    end
    if (out_load) begin
      out_item_q.read_value  <= rd_value;
      out_item_q.highest_bin <= hb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      t_q         <= '0;
      max_scan_q  <= ppmw_pkg::SCAN_W'(ppmw_pkg::SCAN_FIRST);
      hb_q        <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < ppmw_pkg::NUM_TARGETS; k++) begin
        totals_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (q_pop_o) begin
        t_q <= '0;
      end else if (state_q == ST_ACC) begin
        t_q <= t_q + 1'b1;
      end
      if ((state_q == ST_ACC) && hit) begin
        totals_q[t_q] <= ppmw_pkg::sat_add(totals_q[t_q], item_q.inten);
        if (item_q.scan > max_scan_q) begin
          max_scan_q <= item_q.scan;
          hb_q       <= item_q.hb;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("back state not one-hot");

  a_mem_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_ACC))
    else $error("bin memory written outside clear or accumulate");

  a_max_scan_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_scan_q >= $past(max_scan_q))
    else $error("highest matched scan went down");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_q)
    else $error("result pending during clearing pass");
`endif

endmodule

// File: hdl/ppm_window_ion_chromatogram_unit.sv
// Top level of the ppm window ion chromatogram unit: APB register file,
// front, queue and back. Depends on ppmw_pkg, ppmw_front, ppmw_queue, ppmw_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries items: an
//   accumulate item adds a spectrum point to every active target whose ppm
//   window holds its mass; a read item returns one total or one time bin.
//   Output channel (out_valid_o / out_stall_i / out_item_o) gives one result
//   per read item, none per accumulate item.
//   Registers sit on the APB port at byte address 4*index; write them only
//   while the block is idle.
// Timing:
//   An item enters the queue at the edge that accepts it. A read item is popped,
//   reads its bin and loads the result register behind out_valid_o, waiting
//   while a stalled result holds it. An accumulate item is popped and then takes
//   diff, multiply and compare-accumulate steps for each active target in turn.
//   The two-entry queue lets the front keep taking items meanwhile.
// Reset:
//   Registers return to their defaults and the bin memory is swept to zero,
//   one entry a cycle, through all NUM_BINS*NUM_TARGETS (512) entries; in_stall_o
//   stays high until the sweep ends. A stalled result holds in the output
//   register; the back end waits and the queue absorbs incoming items.
module ppm_window_ion_chromatogram_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ppmw_pkg::in_item_t           in_item_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ppmw_pkg::out_item_t          out_item_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppmw_pkg::PADDR_W-1:0] paddr,
  input  logic [ppmw_pkg::DATA_W-1:0]  pwdata,
  output logic [ppmw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [ppmw_pkg::TOL_W-1:0]                   tol_q;
  logic [ppmw_pkg::TCNT_W-1:0]                  tcnt_q;
  logic [ppmw_pkg::NUM_TARGETS-1:0][ppmw_pkg::MASS_W-1:0] mass_q;

  ppmw_pkg::cfg_idx_e  reg_idx;
  logic                reg_wr;
  ppmw_pkg::cfg_t      cfg;

  logic                push;
  ppmw_pkg::entry_t    entry;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  ppmw_pkg::entry_t    q_head;
  logic                clearing;

  // Register decode: word address picks the register
  always_comb begin
    pready  = 1'b1;
    reg_idx = ppmw_pkg::cfg_idx_e'(paddr[ppmw_pkg::PADDR_W-1:2]);
    reg_wr  = psel & penable & pwrite;
    prdata  = '0;
    case (reg_idx)
      ppmw_pkg::CFG_TOL:  prdata = ppmw_pkg::DATA_W'(tol_q);
      ppmw_pkg::CFG_TCNT: prdata = ppmw_pkg::DATA_W'(tcnt_q);
      default: begin
        for (int k = 0; k < ppmw_pkg::NUM_TARGETS; k++) begin
          if (32'(reg_idx) == 32'(ppmw_pkg::CFG_MASS_A) + k) begin
            prdata = mass_q[k];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= ppmw_pkg::TOL_W'(1000);
      tcnt_q <= '0;
      mass_q <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        ppmw_pkg::CFG_TOL:  tol_q  <= pwdata[ppmw_pkg::TOL_W-1:0];
        ppmw_pkg::CFG_TCNT: tcnt_q <= pwdata[ppmw_pkg::TCNT_W-1:0];
        default: begin
          // mass registers; drop writes past the last target
          for (int k = 0; k < ppmw_pkg::NUM_TARGETS; k++) begin
            if (32'(reg_idx) == 32'(ppmw_pkg::CFG_MASS_A) + k) begin
              mass_q[k] <= pwdata;
            end
          end
        end
      endcase
    end
  end

  // Clamp the target count to the targets that exist
  always_comb begin
    cfg.tol  = tol_q;
    cfg.mass = mass_q;
    if (32'(tcnt_q) > ppmw_pkg::NUM_TARGETS) begin
      cfg.act = ppmw_pkg::ACT_W'(ppmw_pkg::NUM_TARGETS);
    end else begin
      cfg.act = ppmw_pkg::ACT_W'(tcnt_q);
    end
  end

  ppmw_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (entry)
  );

  ppmw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  ppmw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// File: test/tb.sv
// Self-checking testbench for ppm_window_ion_chromatogram_unit: drives points and reads,
// predicts every result in a scoreboard class, and compares field by field.
// Depends on ppmw_pkg and the RTL under hdl.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index with no register behind it; writes there must be dropped
  localparam int CFG_SPARE = 6;
  localparam longint unsigned PPM_DIV = 64'd100_000_000;
  localparam int HB_CAP = (ppmw_pkg::NUM_BINS - 1 < 127) ? ppmw_pkg::NUM_BINS - 1 : 127;
  localparam logic [ppmw_pkg::MASS_W-1:0] MASS_TOP = '1;
  // Accumulate items still in the queue or in the back end can trail the last
  // result; the settle wait lets them finish.
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;

  // Running model of the chromatogram: target totals, per-target time bins and
  // the highest matched scan, plus the results still owed by the block.
  class chromatogram_scoreboard;
    logic [ppmw_pkg::TOL_W-1:0]  tol;
    logic [ppmw_pkg::TCNT_W-1:0] tcnt;
    logic [ppmw_pkg::MASS_W-1:0] tmass[ppmw_pkg::NUM_TARGETS];
    logic [ppmw_pkg::ACC_W-1:0]  totals[ppmw_pkg::NUM_TARGETS];
    logic [ppmw_pkg::ACC_W-1:0]  bin_acc[ppmw_pkg::NUM_BINS][ppmw_pkg::NUM_TARGETS];
    logic [ppmw_pkg::SCAN_W-1:0] top_scan;
    ppmw_pkg::out_item_t         owed_q[$];
    int unsigned                 errors;

    function new();
      tol = ppmw_pkg::TOL_W'(1000);
      tcnt = '0;
      top_scan = ppmw_pkg::SCAN_W'(ppmw_pkg::SCAN_FIRST);
      errors = 0;
      for (int t = 0; t < ppmw_pkg::NUM_TARGETS; t++) begin
        tmass[t] = '0;
        totals[t] = '0;
        for (int b = 0; b < ppmw_pkg::NUM_BINS; b++) bin_acc[b][t] = '0;
      end
    endfunction

    function void set_register(int idx, logic [ppmw_pkg::DATA_W-1:0] v);
      case (idx)
        ppmw_pkg::CFG_TOL: begin
          tol = v[ppmw_pkg::TOL_W-1:0];
        end
        ppmw_pkg::CFG_TCNT: begin
          tcnt = v[ppmw_pkg::TCNT_W-1:0];
        end
        ppmw_pkg::CFG_MASS_A, ppmw_pkg::CFG_MASS_B, ppmw_pkg::CFG_MASS_C,
        ppmw_pkg::CFG_MASS_D: begin
          if (idx - ppmw_pkg::CFG_MASS_A < ppmw_pkg::NUM_TARGETS) begin
            tmass[idx - ppmw_pkg::CFG_MASS_A] = v[ppmw_pkg::MASS_W-1:0];
          end
        end
        default: begin
        end
      endcase
    endfunction

    function logic [ppmw_pkg::ACC_W-1:0] add_clamped(logic [ppmw_pkg::ACC_W-1:0] a,
                                                     logic [ppmw_pkg::INTEN_W-1:0] v);
      logic [ppmw_pkg::ACC_W:0] s;
      s = {1'b0, a} + {{(ppmw_pkg::ACC_W + 1 - ppmw_pkg::INTEN_W){1'b0}}, v};
      if (s[ppmw_pkg::ACC_W]) return {ppmw_pkg::ACC_W{1'b1}};
      return s[ppmw_pkg::ACC_W-1:0];
    endfunction

    // Exact integer form of |m - center| / center <= tol * 1e-8
    function bit in_window(logic [ppmw_pkg::MASS_W-1:0] center,
                           logic [ppmw_pkg::MASS_W-1:0] m);
      longint unsigned d;
      d = (m >= center) ? 64'(m - center) : 64'(center - m);
      return d * PPM_DIV <= 64'(center) * 64'(tol);
    endfunction

    function void note_item(ppmw_pkg::in_item_t it);
      int unsigned         active;
      int unsigned         bin;
      int unsigned         hb;
      ppmw_pkg::out_item_t res;
      if (it.action == ppmw_pkg::OP_ACC) begin
        if (it.scan_number < ppmw_pkg::SCAN_FIRST || it.point_intensity == 0) return;
        active = (tcnt < ppmw_pkg::NUM_TARGETS) ? tcnt : ppmw_pkg::NUM_TARGETS;
        bin = (it.scan_number - ppmw_pkg::SCAN_FIRST) / ppmw_pkg::SCAN_PER_BIN;
        for (int t = 0; t < active; t++) begin
          if (!in_window(tmass[t], it.point_mass)) continue;
          totals[t] = add_clamped(totals[t], it.point_intensity);
          if (it.scan_number > top_scan) top_scan = it.scan_number;
          if (bin < ppmw_pkg::NUM_BINS) begin
            bin_acc[bin][t] = add_clamped(bin_acc[bin][t], it.point_intensity);
          end
        end
      end else begin
        res.read_value = '0;
        if (it.target_select < ppmw_pkg::NUM_TARGETS) begin
          if (it.bin_select == ppmw_pkg::TOTAL_SELECT) begin
            res.read_value = totals[it.target_select];
          end else if (it.bin_select < ppmw_pkg::NUM_BINS) begin
            res.read_value = bin_acc[it.bin_select][it.target_select];
          end
        end
        hb = (top_scan - ppmw_pkg::SCAN_FIRST) / ppmw_pkg::SCAN_PER_BIN;
        if (hb > HB_CAP) hb = HB_CAP;
        res.highest_bin = ppmw_pkg::HB_W'(hb);
        owed_q = {owed_q, res};
      end
    endfunction

    function void check_result(ppmw_pkg::out_item_t got);
      ppmw_pkg::out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result with none owed: read_value %0h highest_bin %0d",
               got.read_value, got.highest_bin);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0h, got %0h", want.read_value, got.read_value);
        errors++;
      end
      if (got.highest_bin !== want.highest_bin) begin
        $error("highest_bin: expected %0d, got %0d", want.highest_bin, got.highest_bin);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  ppmw_pkg::in_item_t            in_item_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  ppmw_pkg::out_item_t           out_item_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ppmw_pkg::PADDR_W-1:0]  paddr;
  logic [ppmw_pkg::DATA_W-1:0]   pwdata;
  logic [ppmw_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  chromatogram_scoreboard sb = new();

  // Stimulus shaping, changed phase by phase
  int scan_reach;   // highest bin that ordinary points land in
  bit wide_scans;   // allow scans past the last bin and over the full field
  bit calm;         // no gaps on the input side and no stalls on the output side
  bit hold_req;     // ask the receiver for one long hold-off

  ppm_window_ion_chromatogram_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stall pattern, a long hold-off on request, none while calm
  initial begin : receiver
    int r;
    int len;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(1, 6);
        end else if (r < 92) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          len = $urandom_range(15, 60);
        end
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Check every result taken by the receiver against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // One register write: setup cycle, then access cycle until pready
  task automatic apb_write(int idx, logic [ppmw_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ppmw_pkg::PADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic configure(int tol, int tcnt,
                           logic [ppmw_pkg::MASS_W-1:0] ma, logic [ppmw_pkg::MASS_W-1:0] mb,
                           logic [ppmw_pkg::MASS_W-1:0] mc, logic [ppmw_pkg::MASS_W-1:0] md);
    apb_write(ppmw_pkg::CFG_TOL, ppmw_pkg::DATA_W'(tol));
    apb_write(ppmw_pkg::CFG_TCNT, ppmw_pkg::DATA_W'(tcnt));
    apb_write(ppmw_pkg::CFG_MASS_A, ma);
    apb_write(ppmw_pkg::CFG_MASS_B, mb);
    apb_write(ppmw_pkg::CFG_MASS_C, mc);
    apb_write(ppmw_pkg::CFG_MASS_D, md);
  endtask

  // Offer one item, hold it until taken, then idle for the given gap.
  // Valid stays high when gap is zero so back-to-back items never toggle it.
  task automatic send_item(ppmw_pkg::in_item_t it, int gap);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every owed result, then let trailing points settle
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int r;
    if (calm || hold_req) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ppmw_pkg::in_item_t mk(ppmw_pkg::op_e op, int unsigned scan,
                                            logic [ppmw_pkg::MASS_W-1:0] mass,
                                            logic [ppmw_pkg::INTEN_W-1:0] inten,
                                            int tsel, int bsel);
    ppmw_pkg::in_item_t it;
    it.action          = op;
    it.scan_number     = ppmw_pkg::SCAN_W'(scan);
    it.point_mass      = mass;
    it.point_intensity = inten;
    it.target_select   = ppmw_pkg::TSEL_W'(tsel);
    it.bin_select      = ppmw_pkg::BSEL_W'(bsel);
    return it;
  endfunction

  function automatic logic [ppmw_pkg::MASS_W-1:0] pick_target_mass();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return MASS_TOP;
    return $urandom_range(1_000_000, 40_000_000);
  endfunction

  // Mass around a target: dead center, on either window edge, one step past
  // either edge, somewhere inside, or anywhere at all
  function automatic logic [ppmw_pkg::MASS_W-1:0] near_mass(
      logic [ppmw_pkg::MASS_W-1:0] center, logic [ppmw_pkg::TOL_W-1:0] tol);
    longint w;
    longint m;
    w = (longint'(center) * longint'(tol)) / 100_000_000;
    case ($urandom_range(0, 9))
      0: m = center;
      1: m = center + w;
      2: m = center - w;
      3: m = center + w + 1;
      4: m = center - w - 1;
      5, 6, 7: m = center - w + longint'($urandom_range(0, 32'(2 * w)));
      default: m = longint'($urandom);
    endcase
    if (m < 0) m = 0;
    if (m > longint'(MASS_TOP)) m = longint'(MASS_TOP);
    return ppmw_pkg::MASS_W'(m);
  endfunction

  function automatic logic [ppmw_pkg::SCAN_W-1:0] pick_scan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return ppmw_pkg::SCAN_W'($urandom_range(0, ppmw_pkg::SCAN_FIRST - 1));
    if (r < 88 || !wide_scans) begin
      return ppmw_pkg::SCAN_W'(ppmw_pkg::SCAN_FIRST +
             $urandom_range(0, (scan_reach + 1) * ppmw_pkg::SCAN_PER_BIN - 1));
    end
    if (r < 94) begin
      return ppmw_pkg::SCAN_W'(ppmw_pkg::SCAN_FIRST +
             $urandom_range((ppmw_pkg::NUM_BINS - 1) * ppmw_pkg::SCAN_PER_BIN,
                            (ppmw_pkg::NUM_BINS + 4) * ppmw_pkg::SCAN_PER_BIN));
    end
    return ppmw_pkg::SCAN_W'($urandom_range(0, 24'hFF_FFFF));
  endfunction

  function automatic logic [ppmw_pkg::INTEN_W-1:0] pick_intensity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return '1;
    if (r < 25) return $urandom_range(1, 255);
    return $urandom;
  endfunction

  function automatic logic [ppmw_pkg::BSEL_W-1:0] pick_bin_select();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return ppmw_pkg::BSEL_W'(ppmw_pkg::TOTAL_SELECT);
    if (r < 75) return ppmw_pkg::BSEL_W'($urandom_range(0, scan_reach));
    if (r < 85) return ppmw_pkg::BSEL_W'($urandom_range(0, ppmw_pkg::NUM_BINS - 1));
    return ppmw_pkg::BSEL_W'($urandom_range(0, 255));
  endfunction

  // Mostly points aimed at the targets and reads of bins in use, some noise
  function automatic ppmw_pkg::in_item_t next_item();
    ppmw_pkg::in_item_t it;
    int r;
    it.action          = 1'($urandom_range(0, 1));
    it.scan_number     = ppmw_pkg::SCAN_W'($urandom_range(0, 24'hFF_FFFF));
    it.point_mass      = $urandom;
    it.point_intensity = $urandom;
    it.target_select   = ppmw_pkg::TSEL_W'($urandom_range(0, 3));
    it.bin_select      = ppmw_pkg::BSEL_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 5) return it;
    if (r < 65) begin
      it.action          = ppmw_pkg::OP_ACC;
      it.scan_number     = pick_scan();
      it.point_mass      = near_mass(sb.tmass[$urandom_range(0, ppmw_pkg::NUM_TARGETS - 1)],
                                     sb.tol);
      it.point_intensity = pick_intensity();
    end else begin
      it.action     = ppmw_pkg::OP_READ;
      it.bin_select = pick_bin_select();
    end
    return it;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_item(next_item(), pick_gap());
    wait_for_results();
  endtask

  task automatic run_plan(ref ppmw_pkg::in_item_t plan[$]);
    foreach (plan[i]) send_item(plan[i], pick_gap());
    wait_for_results();
    plan.delete();
  endtask

  initial begin : stimulus
    ppmw_pkg::in_item_t plan[$];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    scan_reach  = 7;
    wide_scans  = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Hold off until the bin memory sweep after reset is over
    while (in_stall_o) @(posedge clk_i);

    // Directed: a and b overlap so one point hits both; c gets window edges;
    // d sits at the top of the mass field.
    configure(1000, 4, 32'd5_000_000, 32'd5_000_003, 32'd12_345_678, MASS_TOP);
    plan = {plan, mk(ppmw_pkg::OP_ACC, 120, 32'd5_000_000, 32'd1, 0, 0)};
    plan = {plan, mk(ppmw_pkg::OP_ACC, 119, 32'd5_000_000, 32'd1000, 1, 3)};  // below first scan
    plan = {plan, mk(ppmw_pkg::OP_ACC, 150, 32'd5_000_000, 32'd0, 2, 255)};   // zero intensity
    plan = {plan, mk(ppmw_pkg::OP_ACC, 179, 32'd12_345_801, '1, 3, 128)};     // upper edge of c
    plan = {plan, mk(ppmw_pkg::OP_ACC, 180, 32'd12_345_554, 32'd7, 0, 0)};    // just under c
    plan = {plan, mk(ppmw_pkg::OP_ACC, 180, 32'd12_345_555, 32'd9, 0, 0)};    // lower edge of c
    plan = {plan, mk(ppmw_pkg::OP_ACC, 181, 32'd12_345_802, 32'd11, 0, 0)};   // just over c
    plan = {plan, mk(ppmw_pkg::OP_ACC, 420, MASS_TOP, 32'h8000_0000, 0, 0)};
    plan = {plan, mk(ppmw_pkg::OP_ACC, 421, MASS_TOP - 32'd42_949, 32'd3, 0, 0)};
    for (int t = 0; t < ppmw_pkg::NUM_TARGETS; t++) begin
      plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, t, ppmw_pkg::TOTAL_SELECT)};
    end
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 2, 0)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 2, 1)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 3, 5)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 0, 0)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 1, 129)};                    // unknown bin
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 0, 255)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 1, ppmw_pkg::NUM_BINS - 1)};
    run_plan(plan);

    // Zero tolerance: only exact masses count
    scan_reach = 3;
    configure(0, 4, pick_target_mass(), pick_target_mass(), pick_target_mass(),
              pick_target_mass());
    run_random(150);

    // Widest window, a single target, no idling on either side
    scan_reach = 7;
    calm = 1'b1;
    configure(100_000, 1, pick_target_mass(), pick_target_mass(), pick_target_mass(),
              pick_target_mass());
    run_random(150);
    calm = 1'b0;

    // No active target: points change nothing, reads return what is stored;
    // also poke the unused register index, which must be dropped
    configure($urandom_range(0, 100_000), 0, pick_target_mass(), pick_target_mass(),
              pick_target_mass(), pick_target_mass());
    apb_write(CFG_SPARE, $urandom);
    run_random(60);

    // Count above the target total; receiver holds off while items keep coming
    scan_reach = 15;
    configure($urandom_range(0, 100_000), 7, pick_target_mass(), pick_target_mass(),
              pick_target_mass(), pick_target_mass());
    hold_req = 1'b1;
    run_random(200);

    scan_reach = 40;
    configure($urandom_range(0, 100_000), 2, pick_target_mass(), pick_target_mass(),
              pick_target_mass(), pick_target_mass());
    run_random(150);

    scan_reach = ppmw_pkg::NUM_BINS - 1;
    configure($urandom_range(0, 100_000), 5, pick_target_mass(), pick_target_mass(),
              pick_target_mass(), pick_target_mass());
    run_random(200);

    // Last bin, past the last bin and the top scan; target a at mass zero
    // matches only mass zero, target b at the top of the field
    wide_scans = 1'b1;
    configure($urandom_range(0, 100_000), 4, '0, MASS_TOP, pick_target_mass(),
              pick_target_mass());
    plan = {plan, mk(ppmw_pkg::OP_ACC,
                     ppmw_pkg::SCAN_FIRST + (ppmw_pkg::NUM_BINS - 1) * ppmw_pkg::SCAN_PER_BIN,
                     '0, 32'd5, 0, 0)};
    plan = {plan, mk(ppmw_pkg::OP_ACC,
                     ppmw_pkg::SCAN_FIRST + ppmw_pkg::NUM_BINS * ppmw_pkg::SCAN_PER_BIN - 1,
                     MASS_TOP, '1, 0, 0)};
    plan = {plan, mk(ppmw_pkg::OP_ACC,
                     ppmw_pkg::SCAN_FIRST + ppmw_pkg::NUM_BINS * ppmw_pkg::SCAN_PER_BIN,
                     '0, 32'd11, 0, 0)};
    plan = {plan, mk(ppmw_pkg::OP_ACC, 24'hFF_FFFF, '0, 32'd13, 0, 0)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 0, ppmw_pkg::NUM_BINS - 1)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 1, ppmw_pkg::NUM_BINS - 1)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 0, ppmw_pkg::TOTAL_SELECT)};
    plan = {plan, mk(ppmw_pkg::OP_READ, 0, 0, 0, 1, ppmw_pkg::TOTAL_SELECT)};
    run_plan(plan);
    run_random(240);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
